// ----- hdl/osfir_pkg.sv -----
`timescale 1ns / 1ps

package osfir_pkg;

  // Twiddles are defined on a 64-point circle; shorter transforms stride through it.
  localparam int TwLog = 5;

  // One complex point of the frame, Q16.16 in both parts.
  typedef struct packed {
    logic signed [31:0] re;
    logic signed [31:0] im;
  } cplx_t;

  // Narrow complex factor: a twiddle or a response bin, both below 2^17 in size.
  typedef struct packed {
    logic signed [17:0] re;
    logic signed [17:0] im;
  } wfac_t;

  // Which transform the shared butterfly unit is working on.
  typedef enum logic [1:0] {
    PASS_RSP = 2'd0,
    PASS_FWD = 2'd1,
    PASS_INV = 2'd2
  } pass_e;

  // Frame memory banks.
  localparam logic [1:0] BankFwd = 2'd0;
  localparam logic [1:0] BankInv = 2'd1;
  localparam logic [1:0] BankRsp = 2'd2;

  // Datapath operations issued by the controller.
  typedef enum logic [3:0] {
    DP_IDLE   = 4'd0,
    DP_INIT   = 4'd1,
    DP_SAMPLE = 4'd2,
    DP_LD_RD  = 4'd3,
    DP_LD_WR  = 4'd4,
    DP_BF_RD  = 4'd5,
    DP_BF_MUL = 4'd6,
    DP_PM_RD  = 4'd7,
    DP_PM_MUL = 4'd8,
    DP_RND    = 4'd9,
    DP_BF_WP  = 4'd10,
    DP_BF_WQ  = 4'd11,
    DP_PM_WR  = 4'd12,
    DP_OUT_RD = 4'd13,
    DP_OUT_LD = 4'd14
  } dp_op_e;

  // Command from the controller to the datapath.
  typedef struct packed {
    dp_op_e op;
    pass_e  pass;
  } dp_cmd_t;

  function automatic logic [1:0] bank_of(input pass_e p);
    logic [1:0] b;
    case (p)
      PASS_FWD: b = BankFwd;
      PASS_INV: b = BankInv;
      default:  b = BankRsp;
    endcase
    return b;
  endfunction

  // Quarter-wave cosine, round(65536 * cos(pi * k / 32)).
  function automatic logic signed [17:0] qcos(input logic [4:0] k);
    logic signed [17:0] v;
    case (k)
      5'd0:    v = 18'sd65536;
      5'd1:    v = 18'sd65220;
      5'd2:    v = 18'sd64277;
      5'd3:    v = 18'sd62714;
      5'd4:    v = 18'sd60547;
      5'd5:    v = 18'sd57798;
      5'd6:    v = 18'sd54491;
      5'd7:    v = 18'sd50660;
      5'd8:    v = 18'sd46341;
      5'd9:    v = 18'sd41576;
      5'd10:   v = 18'sd36410;
      5'd11:   v = 18'sd30893;
      5'd12:   v = 18'sd25080;
      5'd13:   v = 18'sd19024;
      5'd14:   v = 18'sd12785;
      5'd15:   v = 18'sd6424;
      default: v = 18'sd0;
    endcase
    return v;
  endfunction

  // Twiddle factor for index k of the 64-point circle (half circle is enough).
  function automatic wfac_t twiddle(input logic [4:0] k, input logic inverse);
    wfac_t w;
    logic signed [17:0] c;
    logic signed [17:0] s;
    if (k <= 5'd16) begin
      c = qcos(k);
      s = qcos(5'd16 - k);
    end else begin
      c = -qcos(5'(6'd32 - 6'(k)));
      s = qcos(k - 5'd16);
    end
    w.re = c;
    w.im = inverse ? s : -s;
    return w;
  endfunction

  // Lowpass coefficients in Q16.16.
  function automatic logic signed [31:0] coef_q16(input logic [4:0] k);
    logic signed [31:0] v;
    case (k)
      5'd0, 5'd30:  v = 32'sd13;
      5'd1, 5'd29:  v = -32'sd178;
      5'd2, 5'd28:  v = -32'sd157;
      5'd3, 5'd27:  v = 32'sd232;
      5'd4, 5'd26:  v = 32'sd542;
      5'd5, 5'd25:  v = 32'sd1;
      5'd6, 5'd24:  v = -32'sd1023;
      5'd7, 5'd23:  v = -32'sd846;
      5'd8, 5'd22:  v = 32'sd1117;
      5'd9, 5'd21:  v = 32'sd2388;
      5'd10, 5'd20: v = 32'sd1;
      5'd11, 5'd19: v = -32'sd4303;
      5'd12, 5'd18: v = -32'sd3776;
      5'd13, 5'd17: v = 32'sd5918;
      5'd14, 5'd16: v = 32'sd19667;
      5'd15:        v = 32'sd26216;
      default:      v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ----- hdl/fft_overlap_save_fir.sv -----
`timescale 1ns / 1ps
// Channel   Direction  Handshake                  Payload
// input     in         in_valid_i / in_ready_o    sample_in_i
// output    out        out_valid_o / out_ready_i  sample_out_o, last_of_block_o
//
// While a block is being filled, in_ready_o is high and a sample is taken whenever
// in_valid_i is high. The sample that completes a block starts the frame load, the
// forward transform, the spectrum product, the inverse transform and the output of
// the block; both transforms share one butterfly unit, which reads, multiplies,
// rounds and writes the sum and then the difference of each butterfly.
// After reset the block clears the overlap history and then transforms the
// coefficients before taking samples. No sample is taken from the end of a block
// until its last output is delivered; output stalls simply extend the burst.

module fft_overlap_save_fir import osfir_pkg::*; #(
  parameter int FFT_SIZE  = 64,
  parameter int TAP_COUNT = 31
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] sample_out_o,
  output logic               last_of_block_o
);

  localparam int LogN     = $clog2(FFT_SIZE);
  localparam int Sw       = $clog2(LogN);
  localparam int BlockLen = FFT_SIZE - TAP_COUNT + 1;
  localparam int Cw       = $clog2(BlockLen);

  dp_cmd_t         cmd;
  logic [LogN-1:0] idx, base;
  logic [Sw-1:0]   stage;
  logic [LogN-2:0] bfly;
  logic [Cw-1:0]   fill;

  // Sequencer.
  osfir_ctrl #(
    .FFT_SIZE (FFT_SIZE),
    .TAP_COUNT(TAP_COUNT)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .last_of_block_o(last_of_block_o),
    .cmd_o          (cmd),
    .idx_o          (idx),
    .stage_o        (stage),
    .bfly_o         (bfly),
    .fill_o         (fill),
    .base_o         (base)
  );

  // Memories and arithmetic.
  osfir_dp #(
    .FFT_SIZE (FFT_SIZE),
    .TAP_COUNT(TAP_COUNT)
  ) u_dp (
    .clk_i       (clk_i),
    .cmd_i       (cmd),
    .idx_i       (idx),
    .stage_i     (stage),
    .bfly_i      (bfly),
    .fill_i      (fill),
    .base_i      (base),
    .sample_in_i (sample_in_i),
    .sample_out_o(sample_out_o)
  );

endmodule

// ----- hdl/osfir_dp.sv -----
`timescale 1ns / 1ps

module osfir_dp import osfir_pkg::*; #(
  parameter int FFT_SIZE  = 64,
  parameter int TAP_COUNT = 31,
  localparam int LogN     = $clog2(FFT_SIZE),
  localparam int Sw       = $clog2(LogN),
  localparam int BlockLen = FFT_SIZE - TAP_COUNT + 1,
  localparam int Cw       = $clog2(BlockLen)
) (
  input  logic               clk_i,
  input  dp_cmd_t            cmd_i,
  input  logic [LogN-1:0]    idx_i,
  input  logic [Sw-1:0]      stage_i,
  input  logic [LogN-2:0]    bfly_i,
  input  logic [Cw-1:0]      fill_i,
  input  logic [LogN-1:0]    base_i,
  input  logic signed [15:0] sample_in_i,
  output logic signed [15:0] sample_out_o
);

  localparam int HistLen = TAP_COUNT - 1;
  localparam int Aw      = LogN + 2;

  function automatic logic [LogN-1:0] bit_rev(input logic [LogN-1:0] v);
    logic [LogN-1:0] r;
    for (int i = 0; i < LogN; i++) begin
      r[i] = v[LogN-1-i];
    end
    return r;
  endfunction

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sd2147483647) r = 32'sh7FFFFFFF;
    else if (v < -33'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

  function automatic logic signed [31:0] rnd16_sat(input logic signed [50:0] v);
    logic signed [50:0] r;
    logic signed [31:0] o;
    r = (v + 51'sd32768) >>> 16;
    if (r > 51'sd2147483647) o = 32'sh7FFFFFFF;
    else if (r < -51'sd2147483648) o = 32'sh80000000;
    else o = r[31:0];
    return o;
  endfunction

  // Sample ring: overlap history followed by the block being filled.
  logic [15:0] smp_mem [FFT_SIZE];
  logic [15:0] smp_rd_q;
  logic        smp_we;
  logic [LogN-1:0] smp_wa;
  logic [15:0]     smp_wd;

  // Frame memory: forward, inverse and response banks.
  cplx_t frm_mem [4*FFT_SIZE];
  cplx_t rda_q, rdb_q;
  logic  frm_we, rda_en, rdb_en;
  logic [Aw-1:0] frm_wa, frm_ra_a, frm_ra_b;
  cplx_t frm_wd;

  // Multiplier pipeline registers.
  logic signed [49:0] prod_rr_q, prod_ii_q, prod_ri_q, prod_ir_q;
  cplx_t t_q;

  logic [1:0]      bank;
  logic [LogN-1:0] half_m, bx, addr_p, addr_q, kk;
  logic [5:0]      tw_full;
  wfac_t           tw;
  cplx_t           mul_a;
  wfac_t           mul_w;
  logic signed [32:0] sum_p_re, sum_p_im, dif_p_re, dif_p_im;
  logic signed [32:0] sc_re, sc_im, ov;
  logic signed [50:0] acc_re, acc_im;
  logic signed [15:0] out_sat;

  // Butterfly addressing and twiddle selection.
  always_comb begin
    bank    = bank_of(cmd_i.pass);
    half_m  = (LogN'(1) << stage_i) - LogN'(1);
    bx      = LogN'(bfly_i);
    addr_p  = ((bx & ~half_m) << 1) | (bx & half_m);
    addr_q  = addr_p | (LogN'(1) << stage_i);
    kk      = bx & half_m;
    tw_full = 6'(kk) << (Sw'(TwLog) - stage_i);
    tw      = twiddle(tw_full[4:0], cmd_i.pass == PASS_INV);
  end

  // Multiplier operand selection.
  always_comb begin
    if (cmd_i.op == DP_PM_MUL) begin
      mul_a    = rda_q;
      mul_w.re = rdb_q.re[17:0];
      mul_w.im = rdb_q.im[17:0];
    end else begin
      mul_a = rdb_q;
      mul_w = tw;
    end
  end

  // Sums, scaling and output rounding.
  always_comb begin
    sum_p_re = 33'(rda_q.re) + 33'(t_q.re);
    sum_p_im = 33'(rda_q.im) + 33'(t_q.im);
    dif_p_re = 33'(rda_q.re) - 33'(t_q.re);
    dif_p_im = 33'(rda_q.im) - 33'(t_q.im);
    sc_re    = (33'(t_q.re) + (33'sd1 <<< (LogN - 1))) >>> LogN;
    sc_im    = (33'(t_q.im) + (33'sd1 <<< (LogN - 1))) >>> LogN;
    acc_re   = 51'(prod_rr_q) - 51'(prod_ii_q);
    acc_im   = 51'(prod_ri_q) + 51'(prod_ir_q);
    ov       = (33'(rda_q.re) + 33'sd128) >>> 8;
    if (ov > 33'sd32767) out_sat = 16'sh7FFF;
    else if (ov < -33'sd32768) out_sat = 16'sh8000;
    else out_sat = ov[15:0];
  end

  // Memory port control per operation.
  always_comb begin
    smp_we   = 1'b0;
    smp_wa   = idx_i;
    smp_wd   = '0;
    frm_we   = 1'b0;
    frm_wa   = {bank, addr_p};
    frm_wd   = '0;
    rda_en   = 1'b0;
    rdb_en   = 1'b0;
    frm_ra_a = {bank, addr_p};
    frm_ra_b = {bank, addr_q};
    case (cmd_i.op)
      DP_INIT: begin
        smp_we    = 1'b1;
        frm_we    = 1'b1;
        frm_wa    = {BankRsp, bit_rev(idx_i)};
        frm_wd.re = (32'(idx_i) < 32'(TAP_COUNT)) ? coef_q16(5'(idx_i)) : 32'sd0;
      end
      DP_SAMPLE: begin
        smp_we = 1'b1;
        smp_wa = base_i + LogN'(HistLen) + LogN'(fill_i);
        smp_wd = sample_in_i;
      end
      DP_LD_WR: begin
        frm_we    = 1'b1;
        frm_wa    = {BankFwd, bit_rev(idx_i)};
        frm_wd.re = {{8{smp_rd_q[15]}}, smp_rd_q, 8'h00};
      end
      DP_BF_RD: begin
        rda_en = 1'b1;
        rdb_en = 1'b1;
      end
      DP_BF_WP: begin
        frm_we    = 1'b1;
        frm_wd.re = sat33(sum_p_re);
        frm_wd.im = sat33(sum_p_im);
      end
      DP_BF_WQ: begin
        frm_we    = 1'b1;
        frm_wa    = {bank, addr_q};
        frm_wd.re = sat33(dif_p_re);
        frm_wd.im = sat33(dif_p_im);
      end
      DP_PM_RD: begin
        rda_en   = 1'b1;
        rdb_en   = 1'b1;
        frm_ra_a = {BankFwd, idx_i};
        frm_ra_b = {BankRsp, idx_i};
      end
      DP_PM_WR: begin
        frm_we    = 1'b1;
        frm_wa    = {BankInv, bit_rev(idx_i)};
        frm_wd.re = sc_re[31:0];
        frm_wd.im = sc_im[31:0];
      end
      DP_OUT_RD: begin
        rda_en   = 1'b1;
        frm_ra_a = {BankInv, idx_i};
      end
      default: begin
      end
    endcase
  end

  // Sample ring storage.
  always_ff @(posedge clk_i) begin
    if (smp_we) smp_mem[smp_wa] <= smp_wd;
    if (cmd_i.op == DP_LD_RD) smp_rd_q <= smp_mem[base_i + idx_i];
  end

  // Frame storage with two registered read ports.
  always_ff @(posedge clk_i) begin
    if (frm_we) frm_mem[frm_wa] <= frm_wd;
    if (rda_en) rda_q <= frm_mem[frm_ra_a];
    if (rdb_en) rdb_q <= frm_mem[frm_ra_b];
  end

  // Complex multiplier: four partial products, then round and saturate.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_BF_MUL || cmd_i.op == DP_PM_MUL) begin
      prod_rr_q <= mul_a.re * mul_w.re;
      prod_ii_q <= mul_a.im * mul_w.im;
      prod_ri_q <= mul_a.re * mul_w.im;
      prod_ir_q <= mul_a.im * mul_w.re;
    end
    if (cmd_i.op == DP_RND) begin
      t_q.re <= rnd16_sat(acc_re);
      t_q.im <= rnd16_sat(acc_im);
    end
  end

  // Output sample register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.op == DP_OUT_LD) sample_out_o <= out_sat;
  end

endmodule

// ----- hdl/osfir_ctrl.sv -----
`timescale 1ns / 1ps

module osfir_ctrl import osfir_pkg::*; #(
  parameter int FFT_SIZE  = 64,
  parameter int TAP_COUNT = 31,
  localparam int LogN     = $clog2(FFT_SIZE),
  localparam int Sw       = $clog2(LogN),
  localparam int BlockLen = FFT_SIZE - TAP_COUNT + 1,
  localparam int Cw       = $clog2(BlockLen)
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic            last_of_block_o,
  output dp_cmd_t         cmd_o,
  output logic [LogN-1:0] idx_o,
  output logic [Sw-1:0]   stage_o,
  output logic [LogN-2:0] bfly_o,
  output logic [Cw-1:0]   fill_o,
  output logic [LogN-1:0] base_o
);

  localparam int HistLen = TAP_COUNT - 1;

  typedef enum logic [15:0] {
    ST_INIT    = 16'h0001,
    ST_COLLECT = 16'h0002,
    ST_LD_RD   = 16'h0004,
    ST_LD_WR   = 16'h0008,
    ST_BF_RD   = 16'h0010,
    ST_BF_MUL  = 16'h0020,
    ST_BF_RND  = 16'h0040,
    ST_BF_WP   = 16'h0080,
    ST_BF_WQ   = 16'h0100,
    ST_PM_RD   = 16'h0200,
    ST_PM_MUL  = 16'h0400,
    ST_PM_RND  = 16'h0800,
    ST_PM_WR   = 16'h1000,
    ST_OUT_RD  = 16'h2000,
    ST_OUT_LD  = 16'h4000,
    ST_OUT_HLD = 16'h8000
  } ctrl_state_e;

  ctrl_state_e     state_q, state_d;
  pass_e           pass_q, pass_d;
  logic [LogN-1:0] idx_q, idx_d;
  logic [Sw-1:0]   stage_q, stage_d;
  logic [LogN-2:0] bfly_q, bfly_d;
  logic [Cw-1:0]   fill_q, fill_d;
  logic [LogN-1:0] base_q, base_d;
  logic            last_q, last_d;
  logic            idx_end;

  assign idx_end = (idx_q == LogN'(FFT_SIZE - 1));

  // Sequencer: init, collect, load, FFT, multiply, inverse, emit.
  always_comb begin
    state_d    = state_q;
    pass_d     = pass_q;
    idx_d      = idx_q;
    stage_d    = stage_q;
    bfly_d     = bfly_q;
    fill_d     = fill_q;
    base_d     = base_q;
    last_d     = last_q;
    cmd_o.op   = DP_IDLE;
    cmd_o.pass = pass_q;
    case (state_q)
      ST_INIT: begin
        cmd_o.op = DP_INIT;
        idx_d    = idx_q + LogN'(1);
        if (idx_end) begin
          pass_d  = PASS_RSP;
          stage_d = '0;
          bfly_d  = '0;
          state_d = ST_BF_RD;
        end
      end
      ST_COLLECT: begin
        if (in_valid_i) begin
          cmd_o.op = DP_SAMPLE;
          if (fill_q == Cw'(BlockLen - 1)) begin
            fill_d  = '0;
            idx_d   = '0;
            state_d = ST_LD_RD;
          end else begin
            fill_d = fill_q + Cw'(1);
          end
        end
      end
      ST_LD_RD: begin
        cmd_o.op = DP_LD_RD;
        state_d  = ST_LD_WR;
      end
      ST_LD_WR: begin
        cmd_o.op = DP_LD_WR;
        idx_d    = idx_q + LogN'(1);
        state_d  = ST_LD_RD;
        if (idx_end) begin
          pass_d  = PASS_FWD;
          stage_d = '0;
          bfly_d  = '0;
          state_d = ST_BF_RD;
        end
      end
      ST_BF_RD: begin
        cmd_o.op = DP_BF_RD;
        state_d  = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        cmd_o.op = DP_BF_MUL;
        state_d  = ST_BF_RND;
      end
      ST_BF_RND: begin
        cmd_o.op = DP_RND;
        state_d  = ST_BF_WP;
      end
      ST_BF_WP: begin
        cmd_o.op = DP_BF_WP;
        state_d  = ST_BF_WQ;
      end
      ST_BF_WQ: begin
        cmd_o.op = DP_BF_WQ;
        bfly_d   = bfly_q + (LogN-1)'(1);
        state_d  = ST_BF_RD;
        if (bfly_q == (LogN-1)'(FFT_SIZE / 2 - 1)) begin
          stage_d = stage_q + Sw'(1);
          if (stage_q == Sw'(LogN - 1)) begin
            stage_d = '0;
            case (pass_q)
              PASS_FWD: begin
                idx_d   = '0;
                state_d = ST_PM_RD;
              end
              PASS_INV: begin
                idx_d   = LogN'(HistLen);
                state_d = ST_OUT_RD;
              end
              default: begin
                state_d = ST_COLLECT;
              end
            endcase
          end
        end
      end
      ST_PM_RD: begin
        cmd_o.op = DP_PM_RD;
        state_d  = ST_PM_MUL;
      end
      ST_PM_MUL: begin
        cmd_o.op = DP_PM_MUL;
        state_d  = ST_PM_RND;
      end
      ST_PM_RND: begin
        cmd_o.op = DP_RND;
        state_d  = ST_PM_WR;
      end
      ST_PM_WR: begin
        cmd_o.op = DP_PM_WR;
        idx_d    = idx_q + LogN'(1);
        state_d  = ST_PM_RD;
        if (idx_end) begin
          pass_d  = PASS_INV;
          stage_d = '0;
          bfly_d  = '0;
          state_d = ST_BF_RD;
        end
      end
      ST_OUT_RD: begin
        cmd_o.op = DP_OUT_RD;
        state_d  = ST_OUT_LD;
      end
      ST_OUT_LD: begin
        cmd_o.op = DP_OUT_LD;
        last_d   = idx_end;
        state_d  = ST_OUT_HLD;
      end
      ST_OUT_HLD: begin
        if (out_ready_i) begin
          idx_d   = idx_q + LogN'(1);
          state_d = ST_OUT_RD;
          if (idx_end) begin
            base_d  = base_q + LogN'(BlockLen);
            state_d = ST_COLLECT;
          end
        end
      end
      default: begin
        state_d = ST_INIT;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_INIT;
      pass_q  <= PASS_RSP;
      idx_q   <= '0;
      stage_q <= '0;
      bfly_q  <= '0;
      fill_q  <= '0;
      base_q  <= '0;
      last_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pass_q  <= pass_d;
      idx_q   <= idx_d;
      stage_q <= stage_d;
      bfly_q  <= bfly_d;
      fill_q  <= fill_d;
      base_q  <= base_d;
      last_q  <= last_d;
    end
  end

  assign idx_o           = idx_q;
  assign stage_o         = stage_q;
  assign bfly_o          = bfly_q;
  assign fill_o          = fill_q;
  assign base_o          = base_q;
  assign in_ready_o      = (state_q == ST_COLLECT);
  assign out_valid_o     = (state_q == ST_OUT_HLD);
  assign last_of_block_o = last_q;

endmodule
